// ===== rtl/multimode_hysteresis_thermostat_unit_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the thermostat unit
// shorthand for clocked implication checks with synchronous reset
// ----------------------------------------------------------------------------
`ifndef MULTIMODE_HYSTERESIS_THERMOSTAT_UNIT_ASSERT_SVH
`define MULTIMODE_HYSTERESIS_THERMOSTAT_UNIT_ASSERT_SVH

// same-cycle implication
`define MHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thermostat check failed");

// next-cycle implication
`define MHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thermostat check failed");

`endif

// ===== rtl/mht_pkg.sv =====
// ----------------------------------------------------------------------------
// mht_pkg
// shared types and constants of the thermostat unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mht_pkg;

  localparam int unsigned ERROR_LIMIT = 10;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // divider sizing
  localparam int unsigned DIV_NUM_W = 17;
  localparam int unsigned DIV_DEN_W = 10;
  localparam int unsigned DIV_QUO_W = 7;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_SP   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_HUM_SP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_HYST      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INVERT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SENS_TYPE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SENS_CH   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_AUTO      = 3'd7;

  // modes
  localparam logic [2:0] MODE_WARM     = 3'd0;
  localparam logic [2:0] MODE_COOL     = 3'd1;
  localparam logic [2:0] MODE_HUM      = 3'd2;
  localparam logic [2:0] MODE_TEMP_PWM = 3'd3;
  localparam logic [2:0] MODE_HUM_PWM  = 3'd4;

  // actions
  localparam logic [2:0] ACT_NONE = 3'd0;
  localparam logic [2:0] ACT_ON   = 3'd1;
  localparam logic [2:0] ACT_OFF  = 3'd2;
  localparam logic [2:0] ACT_FAN  = 3'd3;
  localparam logic [2:0] ACT_ERR  = 3'd4;

  // sensor types
  localparam logic [1:0] SENS_UNSET    = 2'd0;
  localparam logic [1:0] SENS_COMBINED = 2'd2;

  // failed-read markers
  localparam logic signed [12:0] TEMP_FAIL = -13'sd2750;
  localparam logic signed [10:0] HUM_FAIL  = -11'sd10;

  // fan mapping
  localparam logic [6:0] FAN_BASE  = 7'd10;
  localparam logic [6:0] FAN_FULL  = 7'd100;
  localparam logic [6:0] FAN_ZERO  = 7'd0;
  localparam logic [DIV_NUM_W-1:0] FAN_SCALE = 17'd90;

  // reset values
  localparam logic signed [12:0] TEMP_SP_RST = 13'sd210;
  localparam logic [9:0]         HUM_SP_RST  = 10'd500;
  localparam logic [9:0]         HYST_RST    = 10'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mht_div.sv =====
// ----------------------------------------------------------------------------
// mht_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mht_div
  import mht_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_QUO_W-1:0]      quo
);

  logic [DIV_NUM_W-1:0] sh_r, sh_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic                 qbit;

  always_comb begin
    trial    = {rem_r, sh_r[DIV_NUM_W-1]};
    qbit     = (trial >= {1'b0, den_r});
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt   = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[DIV_NUM_W-2:0], qbit};
      rem_nxt = qbit ? DIV_DEN_W'(trial - {1'b0, den_r}) : trial[DIV_DEN_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = sh_r[DIV_QUO_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/multimode_hysteresis_thermostat_unit.sv =====
// ----------------------------------------------------------------------------
// multimode_hysteresis_thermostat_unit
// hysteresis relay control and proportional fan drive from sensor readings
// ----------------------------------------------------------------------------
// One reading is taken at a time. A reading that needs no fan mapping has its
// result written to the output register straight from the evaluation state,
// after which the unit returns to idle and can take the next reading. A reading
// inside the fan band of a pwm mode runs through a bit-serial divider (17 steps,
// one quotient bit per cycle) and has its result written from a final state
// once the divider is done, the unit then returning to idle for the next reading.
// A result waiting in the output register holds the unit until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none
`include "multimode_hysteresis_thermostat_unit_assert.svh"

module multimode_hysteresis_thermostat_unit
  import mht_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // channel[3:0], temperature[16:4], humidity_reading[27:17], zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // action[2:0], relay_on[3], pin_level[4], fan_percent[11:5], error_count[15:12]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // configuration
  logic [2:0]        mode_r;
  logic signed [12:0] tsp_r;
  logic [9:0]        hsp_r;
  logic [9:0]        hyst_r;
  logic              inv_r;
  logic [1:0]        stype_r;
  logic [3:0]        schan_r;
  logic              auto_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_WARM;
      tsp_r   <= TEMP_SP_RST;
      hsp_r   <= HUM_SP_RST;
      hyst_r  <= HYST_RST;
      inv_r   <= 1'b0;
      stype_r <= SENS_UNSET;
      schan_r <= '0;
      auto_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:      mode_r  <= cfg_wdata[2:0];
        REG_TEMP_SP:   tsp_r   <= $signed(cfg_wdata[12:0]);
        REG_HUM_SP:    hsp_r   <= cfg_wdata[9:0];
        REG_HYST:      hyst_r  <= cfg_wdata[9:0];
        REG_INVERT:    inv_r   <= cfg_wdata[0];
        REG_SENS_TYPE: stype_r <= cfg_wdata[1:0];
        REG_SENS_CH:   schan_r <= cfg_wdata[3:0];
        REG_AUTO:      auto_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control state
  state_t            state_r, state_nxt;
  logic              relay_r, relay_nxt;
  logic [3:0]        err_r, err_nxt;
  logic              ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;

  // captured reading
  logic [3:0]         ch_r;
  logic signed [12:0] t_r;
  logic signed [10:0] h_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r <= in_tdata[3:0];
      t_r  <= $signed(in_tdata[16:4]);
      h_r  <= $signed(in_tdata[27:17]);
    end
  end

  // evaluation
  logic signed [14:0] t_x, sp_x, hy15, sp_hi, sp_lo, dist_t;
  logic signed [11:0] h_x, hsp_x, hy12, h_lo, dist_h;
  logic               active, t_fail, h_fail, err_hit;
  logic [3:0]         err_inc, err_after;
  logic [2:0]         ev_action;
  logic               ev_relay, ev_div;
  logic [3:0]         ev_err;
  logic [6:0]         ev_fan;
  logic [9:0]         band_dist;

  always_comb begin
    t_x    = {{2{t_r[12]}}, t_r};
    sp_x   = {{2{tsp_r[12]}}, tsp_r};
    hy15   = {5'b0, hyst_r};
    sp_hi  = sp_x + hy15;
    sp_lo  = sp_x - hy15;
    dist_t = sp_x - t_x;
    h_x    = {h_r[10], h_r};
    hsp_x  = {2'b0, hsp_r};
    hy12   = {2'b0, hyst_r};
    h_lo   = hsp_x - hy12;
    dist_h = h_x - h_lo;
    t_fail = (t_r == TEMP_FAIL);
    h_fail = (h_r == HUM_FAIL);
    err_inc   = err_r + 4'd1;
    err_hit   = (err_inc == 4'(ERROR_LIMIT));
    err_after = err_hit ? 4'd0 : err_inc;
    active = auto_r && (stype_r != SENS_UNSET) &&
             ((ch_r == schan_r) || (stype_r == SENS_COMBINED));

    ev_action = ACT_NONE;
    ev_relay  = relay_r;
    ev_err    = err_r;
    ev_fan    = FAN_ZERO;
    ev_div    = 1'b0;
    band_dist = '0;
    if (active) begin
      unique case (mode_r)
        MODE_WARM: begin
          if (t_fail) begin
            ev_action = ACT_ERR;
            ev_err    = err_after;
            if (err_hit) ev_relay = 1'b0;
          end else if (!relay_r && t_x <= sp_x) begin
            ev_relay = 1'b1; ev_action = ACT_ON;
          end else if (relay_r && t_x > sp_hi) begin
            ev_relay = 1'b0; ev_action = ACT_OFF;
          end
        end
        MODE_COOL: begin
          if (t_fail) begin
            ev_action = ACT_ERR;
            ev_err    = err_after;
            if (err_hit) ev_relay = 1'b0;
          end else if (relay_r && t_x < sp_lo) begin
            ev_relay = 1'b0; ev_action = ACT_OFF;
          end else if (!relay_r && t_x >= sp_x) begin
            ev_relay = 1'b1; ev_action = ACT_ON;
          end
        end
        MODE_HUM: begin
          if (relay_r && h_x < h_lo) begin
            ev_relay = 1'b0; ev_action = ACT_OFF;
          end else if (!relay_r && h_x >= hsp_x) begin
            ev_relay = 1'b1; ev_action = ACT_ON;
          end
        end
        MODE_TEMP_PWM: begin
          if (t_fail) begin
            ev_action = ACT_ERR;
            ev_err    = err_after;
          end else begin
            ev_action = ACT_FAN;
            if (t_x < sp_lo) begin
              ev_fan = FAN_FULL; ev_relay = 1'b1;
            end else if (t_x <= sp_x) begin
              ev_div = 1'b1; band_dist = dist_t[9:0];
            end else begin
              ev_fan = FAN_ZERO; ev_relay = 1'b0;
            end
          end
        end
        MODE_HUM_PWM: begin
          if (h_fail) begin
            ev_action = ACT_ERR;
            ev_err    = err_after;
          end else begin
            ev_action = ACT_FAN;
            if (h_x < h_lo) begin
              ev_fan = FAN_ZERO; ev_relay = 1'b0;
            end else if (h_x <= hsp_x) begin
              ev_div = 1'b1; band_dist = dist_h[9:0];
            end else begin
              ev_fan = FAN_FULL; ev_relay = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // fan band divider
  logic                 div_start;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_QUO_W-1:0] div_quo;

  assign div_num = DIV_NUM_W'(DIV_NUM_W'(band_dist) * FAN_SCALE);
  assign div_den = (hyst_r == '0) ? DIV_DEN_W'(1) : hyst_r;

  mht_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer and output register
  logic slot_free;
  assign slot_free = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    relay_nxt = relay_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (ev_div) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (slot_free) begin
          relay_nxt = ev_relay;
          err_nxt   = ev_err;
          ov_nxt    = 1'b1;
          od_nxt    = {ev_err, ev_fan, ev_relay ^ inv_r, ev_relay, ev_action};
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          relay_nxt = 1'b1;
          ov_nxt    = 1'b1;
          od_nxt    = {err_r, FAN_BASE + div_quo, ~inv_r, 1'b1, ACT_FAN};
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      relay_r <= 1'b0;
      err_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      relay_r <= relay_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // checks
  `MHT_ASSERT_NOW(a_err_below_limit, clk, rst_n, 1'b1, err_r < 4'(ERROR_LIMIT))
  `MHT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_acc, !in_tready)
  `MHT_ASSERT_NOW(a_fan_only_on_set, clk, rst_n,
                  ov_r && (od_r[2:0] != ACT_FAN), od_r[11:5] == FAN_ZERO)
  `MHT_ASSERT_NOW(a_fan_in_range, clk, rst_n,
                  ov_r && (od_r[2:0] == ACT_FAN), od_r[11:5] <= FAN_FULL)
  `MHT_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_done, state_r == ST_DIV)

endmodule

`default_nettype wire

// ===== tb/tb_multimode_hysteresis_thermostat_unit.sv =====
// ----------------------------------------------------------------------------
// tb_multimode_hysteresis_thermostat_unit
// Sends sensor readings through the thermostat unit under many register
// settings: a directed opening, then random batches. Readings are drawn
// around the setpoints and hysteresis bands. Each accepted reading is
// predicted in the bench: relay state, fan duty and failed-read count.
// Every result is checked field by field against the oldest prediction.
// Both handshakes stall at random, except in the last batches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multimode_hysteresis_thermostat_unit;
  import mht_pkg::*;

  localparam int TEMP_MAX      = 2000;
  localparam int HUM_MAX       = 1000;
  localparam int RAND_BATCHES  = 14;
  localparam int BATCH_ITEMS   = 34;
  localparam int DRAIN_CYCLES  = 40;
  localparam int STALL_LIMIT   = 5000;

  // channel, temperature, humidity_reading, zero pad (lowest bits last)
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [10:0] humidity;
    logic signed [12:0] temperature;
    logic [3:0]         channel;
  } reading_t;

  // action, relay_on, pin_level, fan_percent, error_count (lowest bits last)
  typedef struct packed {
    logic [3:0] error_count;
    logic [6:0] fan_percent;
    logic       pin_level;
    logic       relay_on;
    logic [2:0] action;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  multimode_hysteresis_thermostat_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register shadows
  logic [2:0]         sh_mode;
  logic signed [12:0] sh_temp_sp;
  logic [9:0]         sh_hum_sp;
  logic [9:0]         sh_hyst;
  logic               sh_invert;
  logic [1:0]         sh_sens_type;
  logic [3:0]         sh_channel;
  logic               sh_auto;

  // thermostat state
  logic       relay = 1'b0;
  logic [3:0] read_errors = '0;

  reading_t pending_readings[$];
  result_t  expected_results[$];
  int       bad_results = 0;
  bit       idle_on = 1'b1;
  int       src_gap = 0;
  int       snk_gap = 0;
  int       stall_cycles = 0;

  function automatic bit count_failed_read();
    read_errors = read_errors + 4'd1;
    if (read_errors == 4'(ERROR_LIMIT)) begin
      read_errors = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_reading(input reading_t r);
    result_t res;
    int t, h, sp, hsp, hy, div, low;
    t   = $signed(r.temperature);
    h   = $signed(r.humidity);
    sp  = $signed(sh_temp_sp);
    hsp = int'(sh_hum_sp);
    hy  = int'(sh_hyst);
    div = (hy < 1) ? 1 : hy;
    res = '0;
    res.action = ACT_NONE;
    res.fan_percent = FAN_ZERO;
    if (sh_auto && sh_sens_type != SENS_UNSET &&
        (r.channel == sh_channel || sh_sens_type == SENS_COMBINED)) begin
      case (sh_mode)
        MODE_WARM: begin
          if (t == int'(TEMP_FAIL)) begin
            res.action = ACT_ERR;
            if (count_failed_read()) relay = 1'b0;
          end else if (!relay && t <= sp) begin
            relay = 1'b1;
            res.action = ACT_ON;
          end else if (relay && t > sp + hy) begin
            relay = 1'b0;
            res.action = ACT_OFF;
          end
        end
        MODE_COOL: begin
          if (t == int'(TEMP_FAIL)) begin
            res.action = ACT_ERR;
            if (count_failed_read()) relay = 1'b0;
          end else if (relay && t < sp - hy) begin
            relay = 1'b0;
            res.action = ACT_OFF;
          end else if (!relay && t >= sp) begin
            relay = 1'b1;
            res.action = ACT_ON;
          end
        end
        MODE_HUM: begin
          if (relay && h < hsp - hy) begin
            relay = 1'b0;
            res.action = ACT_OFF;
          end else if (!relay && h >= hsp) begin
            relay = 1'b1;
            res.action = ACT_ON;
          end
        end
        MODE_TEMP_PWM: begin
          if (t == int'(TEMP_FAIL)) begin
            res.action = ACT_ERR;
            void'(count_failed_read());
          end else begin
            low = sp - hy;
            res.action = ACT_FAN;
            if (t < low) begin
              res.fan_percent = FAN_FULL;
              relay = 1'b1;
            end else if (t <= sp) begin
              res.fan_percent = 7'(int'(FAN_BASE) + ((sp - t) * int'(FAN_SCALE)) / div);
              relay = 1'b1;
            end else begin
              res.fan_percent = FAN_ZERO;
              relay = 1'b0;
            end
          end
        end
        MODE_HUM_PWM: begin
          if (h == int'(HUM_FAIL)) begin
            res.action = ACT_ERR;
            void'(count_failed_read());
          end else begin
            low = hsp - hy;
            res.action = ACT_FAN;
            if (h < low) begin
              res.fan_percent = FAN_ZERO;
              relay = 1'b0;
            end else if (h <= hsp) begin
              res.fan_percent = 7'(int'(FAN_BASE) + ((h - low) * int'(FAN_SCALE)) / div);
              relay = 1'b1;
            end else begin
              res.fan_percent = FAN_FULL;
              relay = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    res.relay_on    = relay;
    res.pin_level   = relay ^ sh_invert;
    res.error_count = read_errors;
    expected_results.push_back(res);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      bad_results++;
      if (bad_results <= 10) $display("result with no reading pending: %h", got);
    end else begin
      want = expected_results.pop_front();
      if (got.action !== want.action || got.relay_on !== want.relay_on ||
          got.pin_level !== want.pin_level || got.fan_percent !== want.fan_percent ||
          got.error_count !== want.error_count) begin
        bad_results++;
        if (bad_results <= 10)
          $display("mismatch exp/act: action %0d/%0d relay %0d/%0d pin %0d/%0d fan %0d/%0d err %0d/%0d",
                   want.action, got.action, want.relay_on, got.relay_on,
                   want.pin_level, got.pin_level, want.fan_percent, got.fan_percent,
                   want.error_count, got.error_count);
      end
    end
  endtask

  // item driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_reading(reading_t'(in_tdata));
        void'(pending_readings.pop_front());
        if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 6);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_readings.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_readings[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(result_t'(out_tdata));
      if (snk_gap > 0) begin
        snk_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) snk_gap = $urandom_range(1, 6);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_MODE:      sh_mode      = v[2:0];
      REG_TEMP_SP:   sh_temp_sp   = v[12:0];
      REG_HUM_SP:    sh_hum_sp    = v[9:0];
      REG_HYST:      sh_hyst      = v[9:0];
      REG_INVERT:    sh_invert    = v[0];
      REG_SENS_TYPE: sh_sens_type = v[1:0];
      REG_SENS_CH:   sh_channel   = v[3:0];
      REG_AUTO:      sh_auto      = v[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_unit(input int mode, input int temp_sp, input int hum_sp,
                              input int hyst, input int invert, input int sens_type,
                              input int channel, input int auto_on);
    cfg_write(REG_MODE, mode);
    cfg_write(REG_TEMP_SP, temp_sp);
    cfg_write(REG_HUM_SP, hum_sp);
    cfg_write(REG_HYST, hyst);
    cfg_write(REG_INVERT, invert);
    cfg_write(REG_SENS_TYPE, sens_type);
    cfg_write(REG_SENS_CH, channel);
    cfg_write(REG_AUTO, auto_on);
  endtask

  task automatic push_reading(input int channel, input int temp, input int hum);
    reading_t r;
    r.pad         = '0;
    r.channel     = 4'(channel);
    r.temperature = 13'(temp);
    r.humidity    = 11'(hum);
    pending_readings.push_back(r);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_readings.size() != 0 || expected_results.size() != 0);
  endtask

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // readings mostly around the setpoints and inside the bands
  task automatic push_random_reading();
    int ch, t, h, span;
    span = int'(sh_hyst) + 20;
    ch = ($urandom_range(0, 3) != 0) ? int'(sh_channel) : int'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0:       t = int'(TEMP_FAIL);
      1:       t = int'(TEMP_FAIL) + int'($urandom_range(0, TEMP_MAX - int'(TEMP_FAIL)));
      default: t = clamp($signed(sh_temp_sp) - span + int'($urandom_range(0, span + 20)),
                         int'(TEMP_FAIL), TEMP_MAX);
    endcase
    case ($urandom_range(0, 5))
      0:       h = int'(HUM_FAIL);
      1:       h = int'(HUM_FAIL) + int'($urandom_range(0, HUM_MAX - int'(HUM_FAIL)));
      default: h = clamp(int'(sh_hum_sp) - span + int'($urandom_range(0, span + 20)),
                         int'(HUM_FAIL), HUM_MAX);
    endcase
    push_reading(ch, t, h);
  endtask

  initial begin
    int m, tsp, hsp, hy;
    sh_mode      = MODE_WARM;
    sh_temp_sp   = TEMP_SP_RST;
    sh_hum_sp    = HUM_SP_RST;
    sh_hyst      = HYST_RST;
    sh_invert    = 1'b0;
    sh_sens_type = SENS_UNSET;
    sh_channel   = '0;
    sh_auto      = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: no sensor type yet, reading ignored
    push_reading(0, 100, 500);
    wait_drained();

    // warming, channel match and mismatch, failed reads up to the limit
    program_unit(MODE_WARM, 210, 500, 10, 0, 1, 5, 1);
    push_reading(3, 0, 0);
    push_reading(5, 210, 0);
    push_reading(5, 220, 0);
    push_reading(5, 221, 0);
    push_reading(5, 0, 0);
    repeat (ERROR_LIMIT) push_reading(5, TEMP_FAIL, 0);
    wait_drained();

    // cooling, zero band, inverted pin
    program_unit(MODE_COOL, 210, 500, 0, 1, 1, 5, 1);
    push_reading(5, 210, 0);
    push_reading(5, 209, 0);
    wait_drained();

    // humidity, combined sensor, failed humidity value as a plain reading
    program_unit(MODE_HUM, 0, 0, 1000, 0, SENS_COMBINED, 9, 1);
    push_reading(2, 0, HUM_FAIL);
    push_reading(2, 0, HUM_MAX);
    wait_drained();

    // temperature fan, widest band
    program_unit(MODE_TEMP_PWM, TEMP_MAX, HUM_MAX, 1000, 0, 1, 15, 1);
    push_reading(15, TEMP_FAIL, 0);
    push_reading(15, 999, 0);
    push_reading(15, 1500, 0);
    push_reading(15, TEMP_MAX, 0);
    wait_drained();

    // humidity fan, zero band
    program_unit(MODE_HUM_PWM, TEMP_FAIL, HUM_MAX, 0, 1, 1, 0, 1);
    push_reading(0, 0, HUM_MAX);
    push_reading(0, 0, 999);
    push_reading(0, 0, HUM_FAIL);
    wait_drained();

    // automatic control off
    program_unit(MODE_WARM, 210, 500, 10, 0, 1, 5, 0);
    push_reading(5, 0, 0);
    wait_drained();

    for (int b = 0; b < RAND_BATCHES; b++) begin
      idle_on = (b < RAND_BATCHES - 2) && ($urandom_range(0, 3) != 0);
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      case ($urandom_range(0, 7))
        0:       tsp = int'(TEMP_FAIL);
        1:       tsp = TEMP_MAX;
        default: tsp = int'(TEMP_FAIL) + int'($urandom_range(0, TEMP_MAX - int'(TEMP_FAIL)));
      endcase
      case ($urandom_range(0, 7))
        0:       hsp = 0;
        1:       hsp = HUM_MAX;
        default: hsp = $urandom_range(0, HUM_MAX);
      endcase
      case ($urandom_range(0, 5))
        0:       hy = 0;
        1:       hy = 1000;
        2:       hy = 1;
        default: hy = $urandom_range(2, 200);
      endcase
      program_unit(m, tsp, hsp, hy, $urandom_range(0, 1),
                   ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3),
                   $urandom_range(0, 15), ($urandom_range(0, 9) == 0) ? 0 : 1);
      repeat (BATCH_ITEMS) push_random_reading();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mht_pkg.sv
rtl/mht_div.sv
rtl/multimode_hysteresis_thermostat_unit.sv
tb/tb_multimode_hysteresis_thermostat_unit.sv
